@@ rtl/core/itp_pkg.sv @@
// Package for the infix to postfix converter.
// Holds character codes, cell control type and the precedence functions.
// No dependencies.
`default_nettype none

package itp_pkg;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;

	typedef struct packed {
		logic push;
		logic pop;
	} itp_shift_t;

	function automatic logic is_operand(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
			(c >= CH_DIG_0 && c <= CH_DIG_9);
	endfunction

	function automatic logic is_muldiv(input logic [7:0] c);
		return c == CH_STAR || c == CH_SLASH || c == CH_PCT;
	endfunction

	function automatic logic pops_before(input logic [7:0] top, input logic [7:0] inc);
		logic r;
		if (top == CH_LPAREN || inc == CH_LPAREN) begin
			r = 1'b0;
		end else if (inc == CH_RPAREN) begin
			r = 1'b1;
		end else if (inc == CH_CARET) begin
			r = 1'b0;
		end else if (top == CH_CARET) begin
			r = 1'b1;
		end else if (is_muldiv(top) && is_muldiv(inc)) begin
			r = 1'b1;
		end else begin
			r = (inc == CH_PLUS) || (inc == CH_MINUS);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/itp_if.sv @@
// Channel interfaces of the infix to postfix converter.
// Input characters and postfix results, valid/ready handshake. No dependencies.
`default_nettype none

interface itp_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] symbol;

	modport source (output valid, output kind, output symbol, input ready);
	modport sink (input valid, input kind, input symbol, output ready);
endinterface

interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       last;
	logic       overflow;

	modport source (output valid, output out_char, output char_valid, output last,
		output overflow, input ready);
	modport sink (input valid, input out_char, input char_valid, input last,
		input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/core/itp_cell.sv @@
// One entry of the shifting operator stack.
// Depends on itp_pkg for the shift control type.
`default_nettype none

module itp_cell (
	input  wire logic               clk,
	input  wire itp_pkg::itp_shift_t shift,
	input  wire logic [7:0]         up_data,
	input  wire logic [7:0]         dn_data,
	output logic [7:0]              data_q
);
	import itp_pkg::*;

	always_ff @(posedge clk) begin
		if (shift.push) begin
			data_q <= up_data;
		end else if (shift.pop) begin
			data_q <= dn_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/infix_to_postfix_converter.sv @@
// Infix to postfix converter: shunting-yard over a chain of stack cells, top at cell 0.
// An accepted character is registered in sym_q and the state register; the first result is
// then written to the output register from the operand, operator or flush state when free.
// Input is taken only when idle. Pops run one per cycle through cell 0 while output is free.
// Reset clears state, stack count, overflow flag and output valid; cells hold no reset.
`default_nettype none

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	itp_in_if.sink    char_in,
	itp_out_if.source char_out
);
	import itp_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_OPND  = 3'd1;
	localparam logic [2:0] ST_OP    = 3'd2;
	localparam logic [2:0] ST_OPFIN = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [7:0]    sym_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          ovf_q, ovf_d;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_cv_q, out_last_q, out_ovf_q;

	logic [7:0]    cell_data [STACK_DEPTH];
	itp_shift_t    shift;

	logic          accept, free, pop_now, fin;
	logic          emit, e_cv, e_last;
	logic [7:0]    e_char;

	assign accept = char_in.valid && char_in.ready;
	assign free   = !out_valid_q || char_out.ready;
	assign pop_now = (cnt_q != '0) && pops_before(cell_data[0], sym_q);
	assign fin    = (state_q == ST_OP && !pop_now) || state_q == ST_OPFIN;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		shift   = '0;
		emit    = 1'b0;
		e_char  = cell_data[0];
		e_cv    = 1'b1;
		e_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (char_in.kind) begin
						state_d = ST_FLUSH;
					end else if (is_operand(char_in.symbol)) begin
						state_d = ST_OPND;
					end else begin
						state_d = ST_OP;
					end
				end
			end
			ST_OPND: begin
				if (free) begin
					emit    = 1'b1;
					e_char  = sym_q;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_OP: begin
				if (pop_now && free) begin
					emit      = 1'b1;
					e_last    = !((cnt_q > CW'(1)) && pops_before(cell_data[1], sym_q));
					shift.pop = 1'b1;
					cnt_d     = cnt_q - CW'(1);
					if (e_last) begin
						state_d = ST_OPFIN;
					end
				end
			end
			ST_OPFIN: begin
			end
			ST_FLUSH: begin
				if (free) begin
					emit = 1'b1;
					if (cnt_q != '0) begin
						shift.pop = 1'b1;
						cnt_d     = cnt_q - CW'(1);
					end else begin
						e_char  = '0;
						e_cv    = 1'b0;
						e_last  = 1'b1;
						ovf_d   = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = ST_IDLE;
			if (cnt_q == '0 || sym_q != CH_RPAREN) begin
				if (cnt_q >= CW'(STACK_DEPTH)) begin
					ovf_d = 1'b1;
				end else begin
					shift.push = 1'b1;
					cnt_d      = cnt_q + CW'(1);
				end
			end else begin
				shift.pop = 1'b1;
				cnt_d     = cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (char_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= char_in.symbol;
		end
		if (emit) begin
			out_char_q <= e_char;
			out_cv_q   <= e_cv;
			out_last_q <= e_last;
			out_ovf_q  <= ovf_q;
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [7:0] up_d, dn_d;
		if (i == 0) begin : g_top
			assign up_d = sym_q;
		end else begin : g_mid
			assign up_d = cell_data[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign dn_d = '0;
		end else begin : g_up
			assign dn_d = cell_data[i+1];
		end
		itp_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.up_data (up_d),
			.dn_data (dn_d),
			.data_q  (cell_data[i])
		);
	end

	assign char_in.ready       = (state_q == ST_IDLE);
	assign char_out.valid      = out_valid_q;
	assign char_out.out_char   = out_char_q;
	assign char_out.char_valid = out_cv_q;
	assign char_out.last       = out_last_q;
	assign char_out.overflow   = out_ovf_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		shift.push |-> (cnt_q < CW'(STACK_DEPTH)))
		else $error("push into a full stack");
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && cnt_q == '0 && free) |=>
		(char_out.valid && char_out.last && !char_out.char_valid))
		else $error("end marker missing after flush");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !char_in.ready)
		else $error("input taken while busy");
`endif

endmodule

`default_nettype wire
